[sv/baro_pressure_temperature_compensation_core_defines.svh]
// assertion macros shared by the compensation core rtl
// no dependencies; expects clk and rst_n in the including scope
`ifndef BARO_PRESSURE_TEMPERATURE_COMPENSATION_CORE_DEFINES_SVH
`define BARO_PRESSURE_TEMPERATURE_COMPENSATION_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define BPTC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define BPTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/bptc_pkg.sv]
// shared types and constants of the pressure/temperature compensation core
// no dependencies
package bptc_pkg;

    localparam int RAW_W   = 24;  // raw converter reading
    localparam int COEF_W  = 16;  // calibration word
    localparam int TEMP_W  = 19;  // temperature result
    localparam int PRES_W  = 22;  // pressure result
    localparam int ADDR_W  = 5;   // apb byte address
    localparam int DATA_W  = 32;  // apb data

    localparam int DT_W    = 25;  // temperature difference
    localparam int D_W     = 18;  // first-order temperature minus reference
    localparam int TMP_W   = 20;  // working temperature
    localparam int FO_W    = 36;  // first-order offset and sensitivity
    localparam int SQ_W    = 35;  // squared temperature deviation
    localparam int CR_W    = 39;  // second-order corrections
    localparam int FI_W    = 40;  // corrected offset and sensitivity

    // apb register indexes
    localparam logic [2:0] REG_SENS_COEFF        = 3'd0;
    localparam logic [2:0] REG_OFFSET_COEFF      = 3'd1;
    localparam logic [2:0] REG_SENS_TEMP_COEFF   = 3'd2;
    localparam logic [2:0] REG_OFFSET_TEMP_COEFF = 3'd3;
    localparam logic [2:0] REG_REF_TEMP          = 3'd4;
    localparam logic [2:0] REG_TEMP_COEFF        = 3'd5;

    typedef struct packed {
        logic [COEF_W-1:0] sens_coeff;
        logic [COEF_W-1:0] offset_coeff;
        logic [COEF_W-1:0] sens_temp_coeff;
        logic [COEF_W-1:0] offset_temp_coeff;
        logic [COEF_W-1:0] ref_temp;
        logic [COEF_W-1:0] temp_coeff;
    } bptc_cfg_t;

    // first-order results
    typedef struct packed {
        logic                    valid;
        logic                    cool;   // below 20.00 C
        logic                    cold;   // below -15.00 C
        logic signed [TMP_W-1:0] temp;   // already corrected by t2
        logic signed [D_W-1:0]   d;
        logic signed [D_W-1:0]   e;
        logic signed [FO_W-1:0]  off;
        logic signed [FO_W-1:0]  sens;
        logic [RAW_W-1:0]        d1;
    } bptc_first_t;

    // second-order corrected values
    typedef struct packed {
        logic                    valid;
        logic signed [TMP_W-1:0] temp;
        logic signed [FI_W-1:0]  off;
        logic signed [FI_W-1:0]  sens;
        logic [RAW_W-1:0]        d1;
    } bptc_second_t;

    typedef struct packed {
        logic                     valid;
        logic signed [TEMP_W-1:0] temperature_centi;
        logic signed [PRES_W-1:0] pressure_pa;
    } bptc_result_t;

endpackage

[sv/bptc_intf.sv]
// stream interfaces for raw readings and compensated results
// depends on bptc_pkg
interface bptc_reading_if;
    import bptc_pkg::*;

    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bptc_result_if;
    import bptc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature_centi;
    logic signed [PRES_W-1:0] pressure_pa;

    modport source (output valid, output temperature_centi, output pressure_pa, input ready);
    modport sink (input valid, input temperature_centi, input pressure_pa, output ready);
endinterface

[sv/bptc_apb_regs.sv]
// apb register file holding the six calibration words
// depends on bptc_pkg
module bptc_apb_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bptc_pkg::ADDR_W-1:0] paddr,
    input  logic [bptc_pkg::DATA_W-1:0] pwdata,
    output logic [bptc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output bptc_pkg::bptc_cfg_t        cfg
);
    import bptc_pkg::*;

    bptc_cfg_t         cfg_reg;
    logic [2:0]        index;
    logic              wr_en;
    logic [COEF_W-1:0] wdata;
    logic [COEF_W-1:0] rd_value;

    assign index  = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign wdata  = pwdata[COEF_W-1:0];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (index)
                REG_SENS_COEFF:        cfg_reg.sens_coeff        <= wdata;
                REG_OFFSET_COEFF:      cfg_reg.offset_coeff      <= wdata;
                REG_SENS_TEMP_COEFF:   cfg_reg.sens_temp_coeff   <= wdata;
                REG_OFFSET_TEMP_COEFF: cfg_reg.offset_temp_coeff <= wdata;
                REG_REF_TEMP:          cfg_reg.ref_temp          <= wdata;
                REG_TEMP_COEFF:        cfg_reg.temp_coeff        <= wdata;
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_SENS_COEFF:        rd_value = cfg_reg.sens_coeff;
            REG_OFFSET_COEFF:      rd_value = cfg_reg.offset_coeff;
            REG_SENS_TEMP_COEFF:   rd_value = cfg_reg.sens_temp_coeff;
            REG_OFFSET_TEMP_COEFF: rd_value = cfg_reg.offset_temp_coeff;
            REG_REF_TEMP:          rd_value = cfg_reg.ref_temp;
            REG_TEMP_COEFF:        rd_value = cfg_reg.temp_coeff;
            default:               rd_value = '0;
        endcase
    end

    assign prdata = {{(DATA_W-COEF_W){1'b0}}, rd_value};

endmodule

[sv/bptc_first_order.sv]
// pipeline stages 1-3: temperature difference, coefficient products,
// first-order temperature, offset and sensitivity; depends on bptc_pkg
module bptc_first_order (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       in_valid,
    input  logic [bptc_pkg::RAW_W-1:0] raw_pressure,
    input  logic [bptc_pkg::RAW_W-1:0] raw_temperature,
    input  bptc_pkg::bptc_cfg_t        cfg,
    output bptc_pkg::bptc_first_t      stage_out
);
    import bptc_pkg::*;

    localparam int PROD_W         = DT_W + COEF_W + 1;
    localparam int SQ_FULL_W      = 2 * DT_W;
    localparam int T2_SHIFT       = 31;
    localparam int T2_W           = 17;
    localparam int TEMP_SHIFT     = 23;
    localparam int OFF_SHIFT      = 7;
    localparam int SENS_SHIFT     = 8;
    localparam int OFF_BASE_SHIFT = 16;
    localparam int SENS_BASE_SHIFT = 15;
    localparam int OFF_LIN_W      = PROD_W - OFF_SHIFT;
    localparam int SENS_LIN_W     = PROD_W - SENS_SHIFT;

    localparam logic signed [TMP_W-1:0] TEMP_REF  = 20'sd2000;
    localparam logic signed [TMP_W-1:0] TEMP_COLD = -20'sd1500;

    // stage 1
    logic                     s1_valid_reg;
    logic signed [DT_W-1:0]   s1_dt_reg, dt_next;
    logic [RAW_W-1:0]         s1_d1_reg;

    // stage 2
    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] s2_ptemp_reg, ptemp_next;
    logic signed [PROD_W-1:0] s2_poff_reg, poff_next;
    logic signed [PROD_W-1:0] s2_psens_reg, psens_next;
    logic [T2_W-1:0]          s2_t2_reg, t2_next;
    logic [RAW_W-1:0]         s2_d1_reg;
    logic signed [SQ_FULL_W-1:0] dt_sq;

    // stage 3
    logic                     s3_valid_reg;
    logic                     s3_cool_reg, cool_next;
    logic                     s3_cold_reg, cold_next;
    logic signed [TMP_W-1:0]  s3_temp_reg, temp_next;
    logic signed [D_W-1:0]    s3_d_reg, d_next;
    logic signed [D_W-1:0]    s3_e_reg, e_next;
    logic signed [FO_W-1:0]   s3_off_reg, off_next;
    logic signed [FO_W-1:0]   s3_sens_reg, sens_next;
    logic [RAW_W-1:0]         s3_d1_reg;

    logic signed [TMP_W-1:0]      temp_first;
    logic signed [TMP_W-1:0]      e_wide;
    logic signed [OFF_LIN_W-1:0]  off_lin;
    logic signed [SENS_LIN_W-1:0] sens_lin;

    assign dt_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, cfg.ref_temp, 8'd0});

    assign ptemp_next = s1_dt_reg * $signed({1'b0, cfg.temp_coeff});
    assign poff_next  = s1_dt_reg * $signed({1'b0, cfg.offset_temp_coeff});
    assign psens_next = s1_dt_reg * $signed({1'b0, cfg.sens_temp_coeff});
    assign dt_sq      = s1_dt_reg * s1_dt_reg;
    assign t2_next    = dt_sq[T2_SHIFT +: T2_W];

    // the arithmetic shifts are taken as slices of the registered products
    assign d_next     = s2_ptemp_reg[TEMP_SHIFT +: D_W];
    assign temp_first = TEMP_REF + $signed({{(TMP_W-D_W){d_next[D_W-1]}}, d_next});
    assign cool_next  = d_next[D_W-1];
    assign cold_next  = temp_first < TEMP_COLD;
    assign e_wide     = temp_first - TEMP_COLD;
    assign e_next     = e_wide[D_W-1:0];
    assign temp_next  = temp_first -
                        (cool_next ? $signed({{(TMP_W-T2_W){1'b0}}, s2_t2_reg}) : '0);

    assign off_lin  = s2_poff_reg[OFF_SHIFT +: OFF_LIN_W];
    assign sens_lin = s2_psens_reg[SENS_SHIFT +: SENS_LIN_W];
    assign off_next = $signed({{(FO_W-COEF_W-OFF_BASE_SHIFT){1'b0}}, cfg.offset_coeff,
                               {OFF_BASE_SHIFT{1'b0}}})
                    + $signed({{(FO_W-OFF_LIN_W){off_lin[OFF_LIN_W-1]}}, off_lin});
    assign sens_next = $signed({{(FO_W-COEF_W-SENS_BASE_SHIFT){1'b0}}, cfg.sens_coeff,
                                {SENS_BASE_SHIFT{1'b0}}})
                     + $signed({{(FO_W-SENS_LIN_W){sens_lin[SENS_LIN_W-1]}}, sens_lin});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_dt_reg    <= dt_next;
            s1_d1_reg    <= raw_pressure;
            s2_ptemp_reg <= ptemp_next;
            s2_poff_reg  <= poff_next;
            s2_psens_reg <= psens_next;
            s2_t2_reg    <= t2_next;
            s2_d1_reg    <= s1_d1_reg;
            s3_cool_reg  <= cool_next;
            s3_cold_reg  <= cold_next;
            s3_temp_reg  <= temp_next;
            s3_d_reg     <= d_next;
            s3_e_reg     <= e_next;
            s3_off_reg   <= off_next;
            s3_sens_reg  <= sens_next;
            s3_d1_reg    <= s2_d1_reg;
        end
    end

    assign stage_out.valid = s3_valid_reg;
    assign stage_out.cool  = s3_cool_reg;
    assign stage_out.cold  = s3_cold_reg;
    assign stage_out.temp  = s3_temp_reg;
    assign stage_out.d     = s3_d_reg;
    assign stage_out.e     = s3_e_reg;
    assign stage_out.off   = s3_off_reg;
    assign stage_out.sens  = s3_sens_reg;
    assign stage_out.d1    = s3_d1_reg;

endmodule

[sv/bptc_second_order.sv]
// pipeline stages 4-6: second-order corrections below 20.00 C and -15.00 C
// depends on bptc_pkg and the assertion macro header
`include "baro_pressure_temperature_compensation_core_defines.svh"

module bptc_second_order (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  bptc_pkg::bptc_first_t  stage_in,
    output bptc_pkg::bptc_second_t stage_out
);
    import bptc_pkg::*;

    localparam int MUL_W = SQ_W + 3;

    // stage 4
    logic                    s4_valid_reg;
    logic                    s4_cool_reg, s4_cold_reg;
    logic [SQ_W-1:0]         s4_sq_reg, sq_next;
    logic [SQ_W-1:0]         s4_sq2_reg, sq2_next;
    logic signed [TMP_W-1:0] s4_temp_reg;
    logic signed [FO_W-1:0]  s4_off_reg, s4_sens_reg;
    logic [RAW_W-1:0]        s4_d1_reg;
    logic signed [2*D_W-1:0] sq_full, sq2_full;

    // stage 5
    logic                    s5_valid_reg;
    logic [CR_W-1:0]         s5_off2_reg, off2_next;
    logic [CR_W-1:0]         s5_sens2_reg, sens2_next;
    logic signed [TMP_W-1:0] s5_temp_reg;
    logic signed [FO_W-1:0]  s5_off_reg, s5_sens_reg;
    logic [RAW_W-1:0]        s5_d1_reg;
    logic [MUL_W-1:0]        five_sq, seven_sq2, eleven_sq2;

    // stage 6
    logic                    s6_valid_reg;
    logic signed [FI_W-1:0]  s6_off_reg, off_next;
    logic signed [FI_W-1:0]  s6_sens_reg, sens_next;
    logic signed [TMP_W-1:0] s6_temp_reg;
    logic [RAW_W-1:0]        s6_d1_reg;

    assign sq_full  = stage_in.d * stage_in.d;
    assign sq2_full = stage_in.e * stage_in.e;
    assign sq_next  = sq_full[SQ_W-1:0];
    assign sq2_next = sq2_full[SQ_W-1:0];

    // constant multiples by shift and add or subtract, all terms non-negative
    assign five_sq    = {3'b000, s4_sq_reg} + {1'b0, s4_sq_reg, 2'b00};
    assign seven_sq2  = {s4_sq2_reg, 3'b000} - {3'b000, s4_sq2_reg};
    assign eleven_sq2 = {s4_sq2_reg, 3'b000} + {2'b00, s4_sq2_reg, 1'b0}
                      + {3'b000, s4_sq2_reg};

    assign off2_next = s4_cool_reg
                     ? ({{(CR_W-MUL_W+1){1'b0}}, five_sq[MUL_W-1:1]}
                        + (s4_cold_reg ? {{(CR_W-MUL_W){1'b0}}, seven_sq2} : '0))
                     : '0;
    assign sens2_next = s4_cool_reg
                      ? ({{(CR_W-MUL_W+2){1'b0}}, five_sq[MUL_W-1:2]}
                         + (s4_cold_reg ? {{(CR_W-MUL_W+1){1'b0}}, eleven_sq2[MUL_W-1:1]}
                                        : '0))
                      : '0;

    assign off_next  = $signed({{(FI_W-FO_W){s5_off_reg[FO_W-1]}}, s5_off_reg})
                     - $signed({{(FI_W-CR_W){1'b0}}, s5_off2_reg});
    assign sens_next = $signed({{(FI_W-FO_W){s5_sens_reg[FO_W-1]}}, s5_sens_reg})
                     - $signed({{(FI_W-CR_W){1'b0}}, s5_sens2_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_valid_reg <= stage_in.valid;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_cool_reg  <= stage_in.cool;
            s4_cold_reg  <= stage_in.cold;
            s4_sq_reg    <= sq_next;
            s4_sq2_reg   <= sq2_next;
            s4_temp_reg  <= stage_in.temp;
            s4_off_reg   <= stage_in.off;
            s4_sens_reg  <= stage_in.sens;
            s4_d1_reg    <= stage_in.d1;
            s5_off2_reg  <= off2_next;
            s5_sens2_reg <= sens2_next;
            s5_temp_reg  <= s4_temp_reg;
            s5_off_reg   <= s4_off_reg;
            s5_sens_reg  <= s4_sens_reg;
            s5_d1_reg    <= s4_d1_reg;
            s6_off_reg   <= off_next;
            s6_sens_reg  <= sens_next;
            s6_temp_reg  <= s5_temp_reg;
            s6_d1_reg    <= s5_d1_reg;
        end
    end

    assign stage_out.valid = s6_valid_reg;
    assign stage_out.temp  = s6_temp_reg;
    assign stage_out.off   = s6_off_reg;
    assign stage_out.sens  = s6_sens_reg;
    assign stage_out.d1    = s6_d1_reg;

    // the cold band lies inside the cool band
    `BPTC_ASSERT_SAME(a_cold_in_cool, s4_valid_reg && s4_cold_reg, s4_cool_reg, "cold without cool")
    // corrections only ever lower offset and sensitivity
    `BPTC_ASSERT_NEXT(a_corr_lowers, adv && s5_valid_reg, s6_off_reg <= $past(s5_off_reg), "offset rose")
    `BPTC_ASSERT_NEXT(a_stall_hold, !adv && s6_valid_reg, s6_valid_reg && $stable(s6_sens_reg), "stage 6 moved in stall")

endmodule

[sv/bptc_pressure.sv]
// pipeline stages 7-9: split raw pressure times sensitivity, final shifts
// and output saturation; depends on bptc_pkg
module bptc_pressure (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  bptc_pkg::bptc_second_t stage_in,
    output bptc_pkg::bptc_result_t result_out
);
    import bptc_pkg::*;

    localparam int LO_W     = 20;
    localparam int HI_W     = FI_W - LO_W;
    localparam int PLO_W    = RAW_W + LO_W;
    localparam int PHI_W    = RAW_W + 1 + HI_W;
    localparam int PHI_USE  = PHI_W - 1;   // product magnitude stays below 2^43
    localparam int PROD_W   = 64;
    localparam int MUL_SHIFT = 21;
    localparam int OUT_SHIFT = 15;
    localparam int DIFF_W   = PROD_W - MUL_SHIFT + 1;
    localparam int PW_W     = DIFF_W - OUT_SHIFT;

    // stage 7
    logic                    s7_valid_reg;
    logic [PLO_W-1:0]        s7_plo_reg, plo_next;
    logic signed [PHI_W-1:0] s7_phi_reg, phi_next;
    logic signed [FI_W-1:0]  s7_off_reg;
    logic signed [TMP_W-1:0] s7_temp_reg;
    logic [LO_W-1:0]         sens_lo;
    logic signed [HI_W-1:0]  sens_hi;

    // stage 8
    logic                     s8_valid_reg;
    logic signed [PROD_W-1:0] s8_prod_reg, prod_next;
    logic signed [FI_W-1:0]   s8_off_reg;
    logic signed [TMP_W-1:0]  s8_temp_reg;

    // stage 9
    logic                     s9_valid_reg;
    logic signed [TEMP_W-1:0] s9_temp_reg, temp_next;
    logic signed [PRES_W-1:0] s9_pres_reg, pres_next;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PW_W-1:0]   pres_wide;
    logic [PW_W-PRES_W:0]     pres_top;
    logic [TMP_W-TEMP_W:0]    temp_top;

    assign sens_lo  = stage_in.sens[LO_W-1:0];
    assign sens_hi  = stage_in.sens[FI_W-1:LO_W];
    assign plo_next = stage_in.d1 * sens_lo;
    assign phi_next = $signed({1'b0, stage_in.d1}) * sens_hi;

    assign prod_next = $signed({s7_phi_reg[PHI_USE-1:0], {LO_W{1'b0}}})
                     + $signed({{(PROD_W-PLO_W){1'b0}}, s7_plo_reg});

    assign diff = $signed({s8_prod_reg[PROD_W-1], s8_prod_reg[PROD_W-1:MUL_SHIFT]})
                - $signed({{(DIFF_W-FI_W){s8_off_reg[FI_W-1]}}, s8_off_reg});
    assign pres_wide = diff[DIFF_W-1:OUT_SHIFT];

    // saturate when the bits above the field are not a plain sign extension
    assign pres_top = pres_wide[PW_W-1:PRES_W-1];
    assign temp_top = s8_temp_reg[TMP_W-1:TEMP_W-1];

    always_comb
    begin
        if (&pres_top || ~|pres_top)
            pres_next = pres_wide[PRES_W-1:0];
        else if (pres_wide[PW_W-1])
            pres_next = {1'b1, {(PRES_W-1){1'b0}}};
        else
            pres_next = {1'b0, {(PRES_W-1){1'b1}}};

        if (&temp_top || ~|temp_top)
            temp_next = s8_temp_reg[TEMP_W-1:0];
        else if (s8_temp_reg[TMP_W-1])
            temp_next = {1'b1, {(TEMP_W-1){1'b0}}};
        else
            temp_next = {1'b0, {(TEMP_W-1){1'b1}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
            s9_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s7_valid_reg <= stage_in.valid;
            s8_valid_reg <= s7_valid_reg;
            s9_valid_reg <= s8_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_plo_reg  <= plo_next;
            s7_phi_reg  <= phi_next;
            s7_off_reg  <= stage_in.off;
            s7_temp_reg <= stage_in.temp;
            s8_prod_reg <= prod_next;
            s8_off_reg  <= s7_off_reg;
            s8_temp_reg <= s7_temp_reg;
            s9_temp_reg <= temp_next;
            s9_pres_reg <= pres_next;
        end
    end

    assign result_out.valid             = s9_valid_reg;
    assign result_out.temperature_centi = s9_temp_reg;
    assign result_out.pressure_pa       = s9_pres_reg;

endmodule

[sv/baro_pressure_temperature_compensation_core.sv]
// barometric pressure/temperature compensation core, top level
// depends on bptc_pkg, bptc_intf, the assertion macro header and the stage modules
//
// usage
//   reading channel: one transaction carries a raw pressure and a raw
//   temperature conversion; result channel: one transaction per reading with
//   temperature in 0.01 C and pressure in Pa, both saturated to their fields
//   the six calibration words are written over the apb port at byte address
//   4*index while no reading is in flight; pready is always high
//   an accepted reading reaches the result channel through stages 1 to 9;
//   throughput: one reading per cycle unless the result channel stalls, set by the nine-stage
//   pipeline with one multiplier or wide add in each stage
//   reset clears the calibration words and all stage valid bits
//   when the receiver stalls with a result pending, the whole pipeline holds
//   and reading.ready drops in the same cycle; nothing is lost or repeated
`include "baro_pressure_temperature_compensation_core_defines.svh"

module baro_pressure_temperature_compensation_core (
    input  logic                       clk,
    input  logic                       rst_n,
    bptc_reading_if.sink               reading,
    bptc_result_if.source              result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bptc_pkg::ADDR_W-1:0] paddr,
    input  logic [bptc_pkg::DATA_W-1:0] pwdata,
    output logic [bptc_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import bptc_pkg::*;

    bptc_cfg_t    cfg;
    bptc_first_t  first_out;
    bptc_second_t second_out;
    bptc_result_t res;
    logic         adv;
    logic [2:0]   stage_valid;

    // the output register frees up when empty or when its transaction completes
    assign adv           = !res.valid || result.ready;
    assign reading.ready = adv;

    bptc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bptc_first_order u_first (
        .clk             (clk),
        .rst_n           (rst_n),
        .adv             (adv),
        .in_valid        (reading.valid),
        .raw_pressure    (reading.raw_pressure),
        .raw_temperature (reading.raw_temperature),
        .cfg             (cfg),
        .stage_out       (first_out)
    );

    bptc_second_order u_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .stage_in  (first_out),
        .stage_out (second_out)
    );

    bptc_pressure u_pressure (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .stage_in   (second_out),
        .result_out (res)
    );

    assign result.valid             = res.valid;
    assign result.temperature_centi = res.temperature_centi;
    assign result.pressure_pa       = res.pressure_pa;

    assign stage_valid = {first_out.valid, second_out.valid, res.valid};

    // a stalled pipeline keeps every item where it is
    `BPTC_ASSERT_NEXT(a_stall_freeze, !adv, $stable(stage_valid), "pipeline moved during stall")

endmodule

[tb/bptc_compensation_checker.sv]
// scoreboard for the pressure/temperature compensation core
// watches the reading, result and apb channels and keeps its own copy of the
// calibration words; depends on bptc_pkg and bptc_intf
`timescale 1ns / 100ps

module bptc_compensation_checker
    import bptc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    bptc_reading_if           reading,
    bptc_result_if            result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic [DATA_W-1:0] prdata,
    input  logic              pready,
    output int                failures,
    output int                outstanding,
    output int                results_seen,
    output int                cool_seen,
    output int                cold_seen,
    output int                clamped_seen
);

    localparam int     COOL_LIMIT = 2000;
    localparam int     COLD_LIMIT = -1500;
    localparam longint TEMP_LO    = -(longint'(1) <<< (TEMP_W - 1));
    localparam longint TEMP_HI    = (longint'(1) <<< (TEMP_W - 1)) - 1;
    localparam longint PRES_LO    = -(longint'(1) <<< (PRES_W - 1));
    localparam longint PRES_HI    = (longint'(1) <<< (PRES_W - 1)) - 1;

    typedef struct packed {
        logic                     cool;
        logic                     cold;
        logic                     clamped;
        logic signed [TEMP_W-1:0] temperature_centi;
        logic signed [PRES_W-1:0] pressure_pa;
    } compensated_t;

    bptc_cfg_t    cal;
    compensated_t compensated_q[$];

    // second-order compensation, every power-of-two division a floor shift
    function automatic compensated_t compensate(input bptc_cfg_t c,
                                                input logic [RAW_W-1:0] d1,
                                                input logic [RAW_W-1:0] d2);
        compensated_t r;
        longint dt, t, off, sens, t2, off2, sens2, dev, sq, pres;
        dt    = longint'(d2) - longint'(c.ref_temp) * 256;
        t     = COOL_LIMIT + ((dt * longint'(c.temp_coeff)) >>> 23);
        off   = longint'(c.offset_coeff) * 65536
              + ((longint'(c.offset_temp_coeff) * dt) >>> 7);
        sens  = longint'(c.sens_coeff) * 32768
              + ((longint'(c.sens_temp_coeff) * dt) >>> 8);
        t2    = 0;
        off2  = 0;
        sens2 = 0;
        r     = '0;
        r.cool = (t < COOL_LIMIT);
        r.cold = (t < COLD_LIMIT);
        if (r.cool)
        begin
            dev   = t - COOL_LIMIT;
            sq    = dev * dev;
            t2    = (dt * dt) >>> 31;
            off2  = (5 * sq) >>> 1;
            sens2 = (5 * sq) >>> 2;
            if (r.cold)
            begin
                dev   = t - COLD_LIMIT;
                sq    = dev * dev;
                off2  = off2 + 7 * sq;
                sens2 = sens2 + ((11 * sq) >>> 1);
            end
        end
        t    = t - t2;
        off  = off - off2;
        sens = sens - sens2;
        pres = (((longint'(d1) * sens) >>> 21) - off) >>> 15;
        if (t < TEMP_LO)
        begin
            t = TEMP_LO;
            r.clamped = 1'b1;
        end
        else if (t > TEMP_HI)
        begin
            t = TEMP_HI;
            r.clamped = 1'b1;
        end
        if (pres < PRES_LO)
        begin
            pres = PRES_LO;
            r.clamped = 1'b1;
        end
        else if (pres > PRES_HI)
        begin
            pres = PRES_HI;
            r.clamped = 1'b1;
        end
        r.temperature_centi = t[TEMP_W-1:0];
        r.pressure_pa       = pres[PRES_W-1:0];
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] cal_word(input bptc_cfg_t c, input logic [2:0] idx);
        logic [DATA_W-1:0] v;
        v = '0;
        case (idx)
            REG_SENS_COEFF:        v[COEF_W-1:0] = c.sens_coeff;
            REG_OFFSET_COEFF:      v[COEF_W-1:0] = c.offset_coeff;
            REG_SENS_TEMP_COEFF:   v[COEF_W-1:0] = c.sens_temp_coeff;
            REG_OFFSET_TEMP_COEFF: v[COEF_W-1:0] = c.offset_temp_coeff;
            REG_REF_TEMP:          v[COEF_W-1:0] = c.ref_temp;
            REG_TEMP_COEFF:        v[COEF_W-1:0] = c.temp_coeff;
            default:               v = '0;
        endcase
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        compensated_t want;
        logic [2:0]   idx;
        if (!rst_n)
        begin
            cal <= '0;
            compensated_q.delete();
            failures     = 0;
            results_seen = 0;
            cool_seen    = 0;
            cold_seen    = 0;
            clamped_seen = 0;
            outstanding <= 0;
        end
        else
        begin
            idx = paddr[ADDR_W-1:2];
            if (psel && penable && pwrite && pready)
            begin
                case (idx)
                    REG_SENS_COEFF:        cal.sens_coeff        <= pwdata[COEF_W-1:0];
                    REG_OFFSET_COEFF:      cal.offset_coeff      <= pwdata[COEF_W-1:0];
                    REG_SENS_TEMP_COEFF:   cal.sens_temp_coeff   <= pwdata[COEF_W-1:0];
                    REG_OFFSET_TEMP_COEFF: cal.offset_temp_coeff <= pwdata[COEF_W-1:0];
                    REG_REF_TEMP:          cal.ref_temp          <= pwdata[COEF_W-1:0];
                    REG_TEMP_COEFF:        cal.temp_coeff        <= pwdata[COEF_W-1:0];
                    default:               ;
                endcase
            end
            if (psel && penable && !pwrite && pready && idx <= REG_TEMP_COEFF)
            begin
                if (prdata !== cal_word(cal, idx))
                begin
                    $display("%0t: register %0d read expected %0h got %0h",
                             $time, idx, cal_word(cal, idx), prdata);
                    failures++;
                end
            end
            if (reading.valid && reading.ready)
            begin
                want = compensate(cal, reading.raw_pressure, reading.raw_temperature);
                compensated_q.push_back(want);
                cool_seen    += want.cool;
                cold_seen    += want.cold;
                clamped_seen += want.clamped;
            end
            if (result.valid && result.ready)
            begin
                results_seen++;
                if (compensated_q.size() == 0)
                begin
                    $display("%0t: result transaction with nothing expected: temp %0d pres %0d",
                             $time, result.temperature_centi, result.pressure_pa);
                    failures++;
                end
                else
                begin
                    want = compensated_q.pop_front();
                    if (result.temperature_centi !== want.temperature_centi)
                    begin
                        $display("%0t: temperature_centi expected %0d got %0d",
                                 $time, want.temperature_centi, result.temperature_centi);
                        failures++;
                    end
                    if (result.pressure_pa !== want.pressure_pa)
                    begin
                        $display("%0t: pressure_pa expected %0d got %0d",
                                 $time, want.pressure_pa, result.pressure_pa);
                        failures++;
                    end
                end
            end
            outstanding <= compensated_q.size();
        end
    end

endmodule

[tb/tb_baro_pressure_temperature_compensation_core.sv]
// top of the compensation core testbench: clock, reset, calibration writes,
// reading stimulus, result back-pressure and the verdict
// depends on bptc_pkg, bptc_intf, the core and bptc_compensation_checker
`timescale 1ns / 100ps

module tb_baro_pressure_temperature_compensation_core;
    import bptc_pkg::*;

    localparam int         CLK_HALF      = 4;
    localparam int         MAX_CYCLES    = 300000;
    localparam int         DRAIN_CYCLES  = 12;
    localparam int         HOLD_CYCLES   = 80;
    localparam int         IDLE_PCT      = 16;
    localparam int         PHASE_ITEMS   = 210;
    localparam int         COOL_LIMIT    = 2000;
    localparam int         COLD_LIMIT    = -1500;
    localparam longint     TEMP_SCALE    = 64'sd8388608;  // 2**23
    localparam longint     RAW_LIMIT     = (longint'(1) <<< RAW_W) - 1;
    localparam logic [2:0] REG_SPARE_LO  = 3'd6;
    localparam logic [2:0] REG_SPARE_HI  = 3'd7;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int        failures;
    int        outstanding;
    int        results_seen;
    int        cool_seen;
    int        cold_seen;
    int        clamped_seen;
    int        cycle_count = 0;
    int        stall_asks  = 0;
    int        stall_done  = 0;
    int        cal_sets    = 0;
    bit        steady_flow = 1'b0;
    bptc_cfg_t cal;

    bptc_reading_if reading_ch ();
    bptc_result_if  result_ch ();

    baro_pressure_temperature_compensation_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .reading (reading_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bptc_compensation_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .reading      (reading_ch),
        .result       (result_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .failures     (failures),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .cool_seen    (cool_seen),
        .cold_seen    (cold_seen),
        .clamped_seen (clamped_seen)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("run stopped after %0d cycles with %0d results still due",
                     cycle_count, outstanding);
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side back-pressure; a stall request holds ready low for a long stretch
    initial
    begin : result_sink
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stall_done != stall_asks)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                stall_done++;
            end
            else
                result_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // smallest temperature difference that gives a first-order temperature of target
    function automatic longint dt_for_temp(input int target);
        longint num;
        longint c6;
        c6  = longint'(cal.temp_coeff);
        num = longint'(target - COOL_LIMIT) * TEMP_SCALE;
        if (c6 == 0)
            return 0;
        if (num >= 0)
            return (num + c6 - 1) / c6;
        return -((-num) / c6);
    endfunction

    function automatic logic [RAW_W-1:0] raw_at_dt(input longint dt);
        longint v;
        v = longint'(cal.ref_temp) * 256 + dt;
        if (v < 0)
            v = 0;
        else if (v > RAW_LIMIT)
            v = RAW_LIMIT;
        return v[RAW_W-1:0];
    endfunction

    task automatic send_reading(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT)
        begin
            reading_ch.valid <= 1'b0;
            @(posedge clk);
        end
        reading_ch.valid           <= 1'b1;
        reading_ch.raw_pressure    <= p;
        reading_ch.raw_temperature <= t;
        do
            @(posedge clk);
        while (reading_ch.ready !== 1'b1);
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic drain_results();
        reading_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [COEF_W-1:0] value);
        logic [DATA_W-COEF_W-1:0] junk;
        junk = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [2:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_cal(input bptc_cfg_t c);
        logic [COEF_W-1:0] junk;
        apb_write(REG_SENS_COEFF, c.sens_coeff);
        apb_write(REG_OFFSET_COEFF, c.offset_coeff);
        apb_write(REG_SENS_TEMP_COEFF, c.sens_temp_coeff);
        apb_write(REG_OFFSET_TEMP_COEFF, c.offset_temp_coeff);
        apb_write(REG_REF_TEMP, c.ref_temp);
        apb_write(REG_TEMP_COEFF, c.temp_coeff);
        // unmapped indexes must leave the calibration alone
        junk = $urandom;
        apb_write(REG_SPARE_LO, junk);
        junk = $urandom;
        apb_write(REG_SPARE_HI, junk);
        cal = c;
        cal_sets++;
        apb_read(REG_SENS_COEFF);
        apb_read(REG_OFFSET_COEFF);
        apb_read(REG_SENS_TEMP_COEFF);
        apb_read(REG_OFFSET_TEMP_COEFF);
        apb_read(REG_REF_TEMP);
        apb_read(REG_TEMP_COEFF);
    endtask

    task automatic send_corners();
        logic [RAW_W-1:0] p;
        p = $urandom;
        send_reading('0, '0);
        send_reading('1, '1);
        send_reading('0, '1);
        send_reading('1, '0);
        send_reading(24'hAAAAAA, 24'h555555);
        send_reading(24'h555555, 24'hAAAAAA);
        send_reading(p, raw_at_dt(0));
    endtask

    // a fixed reading, both sides of the 20.00 C and -15.00 C tests, plus a deep cold point
    task automatic send_thresholds();
        longint dt;
        logic [RAW_W-1:0] p;
        send_reading(24'd9085466, 24'd8569150);
        dt = dt_for_temp(COOL_LIMIT);
        p  = $urandom;
        send_reading(p, raw_at_dt(dt));
        send_reading(p, raw_at_dt(dt - 1));
        dt = dt_for_temp(COLD_LIMIT);
        send_reading(p, raw_at_dt(dt));
        send_reading(p, raw_at_dt(dt - 1));
        dt = dt_for_temp(COLD_LIMIT - 2500);
        send_reading('1, raw_at_dt(dt));
        send_reading('0, raw_at_dt(dt));
    endtask

    task automatic send_random();
        logic [RAW_W-1:0] p;
        logic [RAW_W-1:0] t;
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            p = $urandom;
        else if (pick < 85)
            p = $urandom_range(255);
        else
            p = RAW_LIMIT[RAW_W-1:0] - $urandom_range(255);
        case ($urandom_range(9))
            0, 1, 2: t = $urandom;
            3, 4, 5: t = raw_at_dt(longint'($urandom_range(524288)) - 262144);
            6, 7:    t = raw_at_dt(dt_for_temp(COOL_LIMIT) + longint'($urandom_range(800)) - 400);
            8:       t = raw_at_dt(dt_for_temp(COLD_LIMIT) + longint'($urandom_range(800)) - 400);
            default: t = $urandom_range(1) ? RAW_LIMIT[RAW_W-1:0] - $urandom_range(15)
                                           : $urandom_range(15);
        endcase
        send_reading(p, t);
    endtask

    initial
    begin : stimulus
        bptc_cfg_t c;
        rst_n                      = 1'b0;
        psel                       = 1'b0;
        penable                    = 1'b0;
        pwrite                     = 1'b0;
        paddr                      = '0;
        pwdata                     = '0;
        reading_ch.valid           = 1'b0;
        reading_ch.raw_pressure    = '0;
        reading_ch.raw_temperature = '0;
        cal                        = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // calibration words straight out of reset
        send_corners();
        repeat (4) send_random();
        drain_results();

        for (int ph = 1; ph <= 8; ph++)
        begin
            case (ph)
                1:       c = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
                2:       c = '1;
                3:       c = '0;
                4:       c = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                5:       c = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF};
                default: c = {$urandom, $urandom, $urandom};
            endcase
            load_cal(c);
            steady_flow = (ph == 2);
            send_corners();
            if (ph == 1)
                send_thresholds();
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // receiver holds off while readings keep coming
                if (ph == 3 && i == 60)
                    stall_asks++;
                if (ph == 5 && i == 100)
                    drain_results();
                send_random();
            end
            steady_flow = 1'b0;
            drain_results();
        end

        $display("covered %0d readings over %0d calibration sets incl. reset and extremes",
                 results_seen, cal_sets);
        $display("%0d below 20.00 C, %0d below -15.00 C, %0d with a saturated output",
                 cool_seen, cold_seen, clamped_seen);
        if (failures == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[baro_pressure_temperature_compensation_core.f]
+incdir+sv
sv/bptc_pkg.sv
sv/bptc_intf.sv
sv/bptc_apb_regs.sv
sv/bptc_first_order.sv
sv/bptc_second_order.sv
sv/bptc_pressure.sv
sv/baro_pressure_temperature_compensation_core.sv
tb/bptc_compensation_checker.sv
tb/tb_baro_pressure_temperature_compensation_core.sv
